@@ rtl/assert_macros.svh @@
// Assertion macros shared by the transcoder RTL.
// Users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BTTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true.
`define BTTU_NEVER(lbl, cond, msg) \
  `BTTU_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/bttu_pkg.sv @@
// Types, constants and UTF-8 helper functions for the BOM text transcoder.
// No dependencies.
package bttu_pkg;

  typedef enum logic [2:0] {
    M_DETECT,
    M_PASS,
    M_U16LE,
    M_U16BE,
    M_U32LE,
    M_FAILED
  } mode_e;

  localparam logic [7:0]  BomFf     = 8'hFF;
  localparam logic [7:0]  BomFe     = 8'hFE;
  localparam logic [7:0]  BomEf     = 8'hEF;
  localparam logic [7:0]  BomBb     = 8'hBB;
  localparam logic [7:0]  BomBf     = 8'hBF;
  localparam logic [31:0] CpMax     = 32'h0010_FFFF;
  localparam logic [31:0] SurLo     = 32'h0000_D800;
  localparam logic [31:0] SurHi     = 32'h0000_DFFF;
  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [31:0] SuppBase  = 32'h0001_0000;
  localparam logic [7:0]  Lead2     = 8'hC0;
  localparam logic [7:0]  Lead3     = 8'hE0;
  localparam logic [7:0]  Lead4     = 8'hF0;
  localparam logic [7:0]  ContMark  = 8'h80;

  // One queued request: raw bytes, an optional code point, error and end flags.
  typedef struct packed {
    logic [2:0][7:0] raw;
    logic [1:0]      nraw;
    logic            cp_v;
    logic [20:0]     cp;
    logic            fail;
    logic            last;
  } entry_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h00007F) n = 3'd1;
    else if (cp <= 21'h0007FF) n = 3'd2;
    else if (cp <= 21'h00FFFF) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] j);
    logic [2:0] sh;
    logic [7:0] b;
    sh = n - 3'd1 - {1'b0, j};
    if (j == 2'd0) begin
      case (n)
        3'd1:    b = {1'b0, cp[6:0]};
        3'd2:    b = Lead2 | {3'b000, cp[10:6]};
        3'd3:    b = Lead3 | {4'b0000, cp[15:12]};
        default: b = Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (sh[1:0])
        2'd0:    b = ContMark | {2'b00, cp[5:0]};
        2'd1:    b = ContMark | {2'b00, cp[11:6]};
        2'd2:    b = ContMark | {2'b00, cp[17:12]};
        default: b = ContMark | {5'b00000, cp[20:18]};
      endcase
    end
    return b;
  endfunction

endpackage

@@ rtl/bttu_if.sv @@
// Valid/ready channel interfaces for the transcoder input and output.
// No dependencies.
interface bttu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bttu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       failed;
  logic       out_last;

  modport source (output valid, output out_byte, output has_byte, output failed,
                  output out_last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input failed,
                  input out_last, output ready);
endinterface

@@ rtl/bttu_front.sv @@
// Front end: BOM detection, code unit assembly and surrogate pairing.
// Depends on bttu_pkg and bttu_in_if; pushes at most one request per byte into the queue.
module bttu_front import bttu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bttu_in_if.sink      in_i,
  input  logic         q_ready_i,
  output logic         push_o,
  output entry_t       entry_o
);

  mode_e       mode_q, mode_d;
  logic [7:0]  pre0_q, pre0_d, pre1_q, pre1_d;
  logic [1:0]  pc_q, pc_d;
  logic [7:0]  us0_q, us0_d, us1_q, us1_d, us2_q, us2_d;
  logic [1:0]  uc_q, uc_d;
  logic [9:0]  hh_q, hh_d;
  logic        hp_q, hp_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        unit_go, cp_go, fail_now;
  logic [15:0] unit_val;
  logic [31:0] cp_val;
  entry_t      ent;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;
  assign b          = in_i.in_byte;
  assign last       = in_i.in_last;

  always_comb begin
    mode_d   = mode_q;
    pre0_d   = pre0_q;
    pre1_d   = pre1_q;
    pc_d     = pc_q;
    us0_d    = us0_q;
    us1_d    = us1_q;
    us2_d    = us2_q;
    uc_d     = uc_q;
    hh_d     = hh_q;
    hp_d     = hp_q;
    unit_go  = 1'b0;
    unit_val = '0;
    cp_go    = 1'b0;
    cp_val   = '0;
    fail_now = 1'b0;
    ent      = '0;
    ent.last = last;

    case (mode_q)
      M_DETECT: begin
        case (pc_q)
          2'd0: begin
            if (b inside {BomFf, BomFe, BomEf}) begin
              pre0_d = b;
              pc_d   = 2'd1;
            end else begin
              mode_d     = M_PASS;
              ent.raw[0] = b;
              ent.nraw   = 2'd1;
            end
          end
          2'd1: begin
            if ((pre0_q == BomFf && b == BomFe) || (pre0_q == BomEf && b == BomBb)) begin
              pre1_d = b;
              pc_d   = 2'd2;
            end else if (pre0_q == BomFe && b == BomFf) begin
              pc_d   = 2'd0;
              mode_d = M_U16BE;
            end else begin
              pc_d       = 2'd0;
              mode_d     = M_PASS;
              ent.raw[0] = pre0_q;
              ent.raw[1] = b;
              ent.nraw   = 2'd2;
            end
          end
          2'd2: begin
            if (pre0_q == BomFf) begin
              if (b == 8'h00) begin
                pc_d = 2'd3;
              end else begin
                pc_d   = 2'd0;
                mode_d = M_U16LE;
                us0_d  = b;
                uc_d   = 2'd1;
              end
            end else if (b == BomBf) begin
              pc_d   = 2'd0;
              mode_d = M_PASS;
            end else begin
              pc_d       = 2'd0;
              mode_d     = M_PASS;
              ent.raw[0] = pre0_q;
              ent.raw[1] = pre1_q;
              ent.raw[2] = b;
              ent.nraw   = 2'd3;
            end
          end
          default: begin
            pc_d = 2'd0;
            if (b == 8'h00) begin
              mode_d = M_U32LE;
            end else begin
              mode_d   = M_U16LE;
              unit_go  = 1'b1;
              unit_val = {b, 8'h00};
            end
          end
        endcase
      end
      M_PASS: begin
        ent.raw[0] = b;
        ent.nraw   = 2'd1;
      end
      M_U16LE, M_U16BE: begin
        if (uc_q == 2'd0) begin
          us0_d = b;
          uc_d  = 2'd1;
        end else begin
          uc_d     = 2'd0;
          unit_go  = 1'b1;
          unit_val = (mode_q == M_U16LE) ? {b, us0_q} : {us0_q, b};
        end
      end
      M_U32LE: begin
        case (uc_q)
          2'd0:    begin us0_d = b; uc_d = 2'd1; end
          2'd1:    begin us1_d = b; uc_d = 2'd2; end
          2'd2:    begin us2_d = b; uc_d = 2'd3; end
          default: begin
            uc_d   = 2'd0;
            cp_go  = 1'b1;
            cp_val = {b, us2_q, us1_q, us0_q};
          end
        endcase
      end
      default: begin
      end
    endcase

    if (unit_go) begin
      if (hp_q) begin
        hp_d = 1'b0;
        if (unit_val >= LowFirst && unit_val <= LowLast) begin
          cp_go  = 1'b1;
          cp_val = SuppBase + {12'h000, hh_q, unit_val[9:0]};
        end else begin
          fail_now = 1'b1;
        end
      end else if (unit_val >= HighFirst && unit_val <= HighLast) begin
        hh_d = unit_val[9:0];
        hp_d = 1'b1;
      end else if (unit_val >= LowFirst && unit_val <= LowLast) begin
        fail_now = 1'b1;
      end else begin
        cp_go  = 1'b1;
        cp_val = {16'h0000, unit_val};
      end
    end

    if (cp_go) begin
      if (cp_val > CpMax || (cp_val >= SurLo && cp_val <= SurHi)) begin
        fail_now = 1'b1;
      end else begin
        ent.cp_v = 1'b1;
        ent.cp   = cp_val[20:0];
      end
    end

    if (fail_now) mode_d = M_FAILED;

    if (last) begin
      if (mode_d == M_DETECT && pc_d != 2'd0 && !(pre0_d == BomFf && pc_d >= 2'd2)) begin
        ent.raw[0] = pre0_d;
        ent.raw[1] = pre1_d;
        ent.nraw   = pc_d;
      end
      if ((mode_d == M_U16LE || mode_d == M_U16BE) && hp_d) fail_now = 1'b1;
      mode_d = M_DETECT;
      pre0_d = '0;
      pre1_d = '0;
      pc_d   = '0;
      us0_d  = '0;
      us1_d  = '0;
      us2_d  = '0;
      uc_d   = '0;
      hh_d   = '0;
      hp_d   = 1'b0;
    end

    ent.fail = fail_now || (last && mode_q == M_FAILED);
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.nraw != 2'd0 || ent.cp_v || ent.fail || ent.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_DETECT;
      pre0_q <= '0;
      pre1_q <= '0;
      pc_q   <= '0;
      us0_q  <= '0;
      us1_q  <= '0;
      us2_q  <= '0;
      uc_q   <= '0;
      hh_q   <= '0;
      hp_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      pre0_q <= pre0_d;
      pre1_q <= pre1_d;
      pc_q   <= pc_d;
      us0_q  <= us0_d;
      us1_q  <= us1_d;
      us2_q  <= us2_d;
      uc_q   <= uc_d;
      hh_q   <= hh_d;
      hp_q   <= hp_d;
    end
  end

endmodule

@@ rtl/bttu_queue.sv @@
// Small request queue between the front and back ends.
// Depends on bttu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bttu_queue import bttu_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   ready_o,
  output logic   head_v_o,
  output entry_t head_o,
  input  logic   pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o  = cnt_q != Full;
  assign head_v_o = cnt_q != '0;
  assign head_o   = mem_q[rd_q];
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && head_v_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  `BTTU_NEVER(a_cnt_range, cnt_q > Full, "queue count beyond depth")
  `BTTU_ASSERT(a_cnt_up, (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1, "bad count")
  `BTTU_ASSERT(a_cnt_dn, (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1, "bad count")

endmodule

@@ rtl/bttu_back.sv @@
// Back end: expands a queued request into UTF-8 result items, one per cycle unless stalled.
// Depends on bttu_pkg, bttu_out_if and assert_macros.svh.
`include "assert_macros.svh"
module bttu_back import bttu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_v_i,
  input  entry_t    head_i,
  output logic      pop_o,
  bttu_out_if.source out_o
);

  logic [3:0] idx_q, idx_d;
  logic [2:0] ncp;
  logic [3:0] n_data, total;
  logic       empty;
  logic       issue;
  logic [3:0] j;
  logic [7:0] r_byte;
  logic       r_has, r_fail, r_last;

  logic       out_v_q;
  logic [7:0] byte_q;
  logic       has_q, fail_q, last_q;

  assign ncp    = head_i.cp_v ? utf8_len(head_i.cp) : 3'd0;
  assign n_data = {2'b00, head_i.nraw} + {1'b0, ncp};
  assign empty  = head_i.last && n_data == 4'd0 && !head_i.fail;
  assign total  = n_data + {3'b000, head_i.fail} + {3'b000, empty};
  assign j      = idx_q - {2'b00, head_i.nraw};

  always_comb begin
    r_byte = '0;
    r_has  = 1'b0;
    r_fail = 1'b0;
    if (idx_q < {2'b00, head_i.nraw}) begin
      r_byte = head_i.raw[idx_q[1:0]];
      r_has  = 1'b1;
    end else if (idx_q < n_data) begin
      r_byte = utf8_byte(head_i.cp, ncp, j[1:0]);
      r_has  = 1'b1;
    end else begin
      r_fail = head_i.fail;
    end
    r_last = head_i.last && (idx_q == total - 4'd1);
  end

  assign issue = head_v_i && (!out_v_q || out_o.ready);
  assign pop_o = issue && (idx_q == total - 4'd1);

  always_comb begin
    idx_d = idx_q;
    if (pop_o) idx_d = '0;
    else if (issue) idx_d = idx_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (issue) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      byte_q <= r_byte;
      has_q  <= r_has;
      fail_q <= r_fail;
      last_q <= r_last;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.out_byte = byte_q;
  assign out_o.has_byte = has_q;
  assign out_o.failed   = fail_q;
  assign out_o.out_last = last_q;

  `BTTU_NEVER(a_idx_range, head_v_i && idx_q >= total, "result index past request")
  `BTTU_NEVER(a_pop_empty, pop_o && !head_v_i, "pop from empty queue")
  `BTTU_ASSERT(a_last_out, (pop_o && head_i.last) |=> out_v_q && last_q, "end mark lost")

endmodule

@@ rtl/bom_text_to_utf8_transcoder.sv @@
// Channel   Dir  Payload                                 Handshake
// in_i      in   in_byte[7:0], in_last                   valid/ready
// out_o     out  out_byte[7:0], has_byte, failed, out_last valid/ready
//
// A byte is taken every cycle while the request queue has room; the front end
// turns it into one request of up to four results in the same cycle.
// The back end issues one result per cycle from the queue head into an output
// register while the output is not stalled, so throughput is one result per cycle.
// Reset is asynchronous and clears the detection state, queue and output valid.
// A stalled output holds its register; the queue fills and then in_i.ready drops.
module bom_text_to_utf8_transcoder import bttu_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bttu_in_if.sink    in_i,
  bttu_out_if.source out_o
);

  logic   push, q_ready, head_v, pop;
  entry_t wr_entry, head;

  bttu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (wr_entry)
  );

  bttu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wr_entry),
    .ready_o  (q_ready),
    .head_v_o (head_v),
    .head_o   (head),
    .pop_i    (pop)
  );

  bttu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_v_i (head_v),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for bom_text_to_utf8_transcoder: byte-order-mark detection, UTF-16/32 to UTF-8.
// Directed table then random texts, checked against an in-bench transcoder model.
// Depends on rtl/bttu_pkg.sv, rtl/bttu_if.sv and rtl/bom_text_to_utf8_transcoder.sv.
`timescale 1ns / 100ps

module tb_top;
  import bttu_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       failed;
    logic       out_last;
  } res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    res_t       want;
  } row_t;

  localparam res_t EndMark = '{8'h00, 1'b0, 1'b0, 1'b1};
  localparam res_t FailEnd = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam res_t NoRes   = '0;
  localparam int   NumRows = 26;
  localparam int   RandomBytes = 90;

  row_t directed_rows [NumRows] = '{
    '{8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFE, 1'b1, 1'b1, EndMark},
    '{8'hEF, 1'b0, 1'b0, NoRes},
    '{8'hBB, 1'b0, 1'b0, NoRes},
    '{8'hBF, 1'b0, 1'b0, NoRes},
    '{8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b1}},
    '{8'hFE, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hD8, 1'b0, 1'b0, NoRes},
    '{8'h3D, 1'b0, 1'b0, NoRes},
    '{8'hDE, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b1, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFE, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'hDC, 1'b1, 1'b1, FailEnd},
    '{8'hFE, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'h41, 1'b1, 1'b1, EndMark},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFE, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'hD8, 1'b1, 1'b1, FailEnd},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bttu_in_if  in_ch ();
  bttu_out_if out_ch ();

  bom_text_to_utf8_transcoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // transcoder model state
  mode_e      cur_mode;
  logic [7:0] pfx [3];
  logic [1:0] pfx_cnt;
  logic [7:0] unit_buf [3];
  logic [1:0] unit_cnt;
  logic [9:0] hi_half;
  logic       half_pend;

  res_t       step_res [$];
  res_t       utf8_expected [$];
  logic [7:0] text_q [$];

  int n_errors;
  int n_checked;
  int n_texts;
  int bytes_sent;
  bit steady;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch: %s got %02h want %02h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic void append_text(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void append_expected(res_t r);
    utf8_expected = {utf8_expected, r};
  endfunction

  function automatic void emit(logic [7:0] b, logic has, logic bad);
    res_t r;
    if (step_res.size() >= 4) return;
    r = '{b, has, bad, 1'b0};
    step_res = {step_res, r};
  endfunction

  function automatic void abort_text();
    cur_mode = M_FAILED;
    emit(8'h00, 1'b0, 1'b1);
  endfunction

  function automatic void emit_cp(logic [31:0] cp);
    if (cp > CpMax || (cp >= SurLo && cp <= SurHi)) begin
      abort_text();
      return;
    end
    if (cp <= 32'h7F) begin
      emit(cp[7:0], 1'b1, 1'b0);
    end else if (cp <= 32'h7FF) begin
      emit(Lead2 | {3'b0, cp[10:6]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp <= 32'hFFFF) begin
      emit(Lead3 | {4'b0, cp[15:12]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[11:6]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      emit(Lead4 | {5'b0, cp[20:18]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[17:12]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[11:6]}, 1'b1, 1'b0);
      emit(ContMark | {2'b0, cp[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  function automatic void take_unit(logic [15:0] u);
    if (half_pend) begin
      half_pend = 1'b0;
      if (u >= LowFirst && u <= LowLast) emit_cp(SuppBase + {12'b0, hi_half, u[9:0]});
      else abort_text();
      return;
    end
    if (u >= HighFirst && u <= HighLast) begin
      hi_half = u[9:0];
      half_pend = 1'b1;
    end else if (u >= LowFirst && u <= LowLast) begin
      abort_text();
    end else begin
      emit_cp({16'b0, u});
    end
  endfunction

  function automatic void u16_byte(logic [7:0] b);
    if (unit_cnt == 2'd0) begin
      unit_buf[0] = b;
      unit_cnt = 2'd1;
      return;
    end
    unit_cnt = 2'd0;
    if (cur_mode == M_U16LE) take_unit({b, unit_buf[0]});
    else take_unit({unit_buf[0], b});
  endfunction

  function automatic void u32_byte(logic [7:0] b);
    if (unit_cnt < 2'd3) begin
      unit_buf[unit_cnt] = b;
      unit_cnt++;
      return;
    end
    unit_cnt = 2'd0;
    emit_cp({b, unit_buf[2], unit_buf[1], unit_buf[0]});
  endfunction

  function automatic void flush_pfx();
    for (int i = 0; i < pfx_cnt; i++) emit(pfx[i], 1'b1, 1'b0);
    pfx_cnt = 2'd0;
    cur_mode = M_PASS;
  endfunction

  function automatic void detect_mark(logic [7:0] b);
    logic [7:0] p0;
    p0 = pfx[0];
    if (pfx_cnt == 2'd0) begin
      if (b == BomFf || b == BomFe || b == BomEf) begin
        pfx[0] = b;
        pfx_cnt = 2'd1;
      end else begin
        cur_mode = M_PASS;
        emit(b, 1'b1, 1'b0);
      end
    end else if (pfx_cnt == 2'd1) begin
      if ((p0 == BomFf && b == BomFe) || (p0 == BomEf && b == BomBb)) begin
        pfx[1] = b;
        pfx_cnt = 2'd2;
      end else if (p0 == BomFe && b == BomFf) begin
        pfx_cnt = 2'd0;
        cur_mode = M_U16BE;
      end else begin
        flush_pfx();
        emit(b, 1'b1, 1'b0);
      end
    end else if (pfx_cnt == 2'd2) begin
      if (p0 == BomFf) begin
        if (b == 8'h00) begin
          pfx[2] = 8'h00;
          pfx_cnt = 2'd3;
        end else begin
          pfx_cnt = 2'd0;
          cur_mode = M_U16LE;
          unit_buf[0] = b;
          unit_cnt = 2'd1;
        end
      end else if (b == BomBf) begin
        pfx_cnt = 2'd0;
        cur_mode = M_PASS;
      end else begin
        flush_pfx();
        emit(b, 1'b1, 1'b0);
      end
    end else begin
      pfx_cnt = 2'd0;
      if (b == 8'h00) begin
        cur_mode = M_U32LE;
      end else begin
        cur_mode = M_U16LE;
        take_unit({b, 8'h00});
      end
    end
  endfunction

  function automatic void clear_text_state();
    cur_mode = M_DETECT;
    pfx = '{default: 8'h00};
    pfx_cnt = 2'd0;
    unit_buf = '{default: 8'h00};
    unit_cnt = 2'd0;
    hi_half = 10'd0;
    half_pend = 1'b0;
  endfunction

  // fills step_res with the results of one input byte
  function automatic void transcode_byte(logic [7:0] b, logic last);
    res_t r;
    step_res.delete();
    case (cur_mode)
      M_DETECT:         detect_mark(b);
      M_PASS:           emit(b, 1'b1, 1'b0);
      M_U16LE, M_U16BE: u16_byte(b);
      M_U32LE:          u32_byte(b);
      default: ;
    endcase
    if (!last) return;
    if (cur_mode == M_DETECT && pfx_cnt > 0) begin
      if (pfx[0] == BomFf && pfx_cnt >= 2'd2) pfx_cnt = 2'd0;
      else flush_pfx();
    end
    if ((cur_mode == M_U16LE || cur_mode == M_U16BE) && half_pend) abort_text();
    if (cur_mode == M_FAILED) begin
      if (step_res.size() == 0 || !step_res[step_res.size() - 1].failed)
        emit(8'h00, 1'b0, 1'b1);
    end else if (step_res.size() == 0) begin
      emit(8'h00, 1'b0, 1'b0);
    end
    r = step_res.pop_back();
    r.out_last = 1'b1;
    step_res = {step_res, r};
    clear_text_state();
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic last, logic typed, res_t want);
    int gap;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    in_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    transcode_byte(b, last);
    if (typed) append_expected(want);
    else foreach (step_res[i]) append_expected(step_res[i]);
    bytes_sent++;
    if (last) n_texts++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_cp();
    logic [31:0] cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= SurLo && cp <= SurHi) cp = cp ^ 32'h4000;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  function automatic void add_unit16(logic le, logic [15:0] u);
    if (le) begin
      append_text(u[7:0]);
      append_text(u[15:8]);
    end else begin
      append_text(u[15:8]);
      append_text(u[7:0]);
    end
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [31:0] cp;
    cp = rand_cp();
    if (cp > 32'hFFFF) cp = cp & 32'h7FFF;
    return cp[15:0];
  endfunction

  function automatic void add_units16(logic le);
    int r;
    logic [31:0] c;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        add_unit16(le, rand_bmp());
      end else if (r < 16) begin
        c = $urandom_range('h10000, 'h10FFFF) - SuppBase;
        add_unit16(le, HighFirst | {6'b0, c[19:10]});
        add_unit16(le, LowFirst | {6'b0, c[9:0]});
      end else if (r == 16) begin
        add_unit16(le, LowFirst | 16'($urandom_range(0, 'h3FF)));
      end else if (r == 17) begin
        add_unit16(le, HighFirst | 16'($urandom_range(0, 'h3FF)));
        add_unit16(le, rand_bmp());
      end else if (r == 18) begin
        add_unit16(le, HighFirst | 16'($urandom_range(0, 'h3FF)));
      end else begin
        add_unit16(le, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      end
    end
    if ($urandom_range(0, 5) == 0) append_text(8'($urandom));
  endfunction

  function automatic void add_cps32();
    int r;
    logic [31:0] cp;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 9);
      if (r < 6) cp = rand_cp();
      else if (r == 6) cp = $urandom_range(SurLo, SurHi);
      else if (r == 7) cp = $urandom | 32'h0011_0000;
      else cp = $urandom_range(0, 1) ? CpMax : 32'h0;
      append_text(cp[7:0]);
      append_text(cp[15:8]);
      append_text(cp[23:16]);
      append_text(cp[31:24]);
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) append_text(8'($urandom));
  endfunction

  function automatic void build_text();
    text_q.delete();
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 6)) append_text(8'($urandom));
      1: begin
        case ($urandom_range(0, 4))
          0: text_q = '{BomFf};
          1: text_q = '{BomFe};
          2: text_q = '{BomEf};
          3: text_q = '{BomEf, BomBb};
          default: text_q = '{BomFf, BomFe, 8'h00};
        endcase
        repeat ($urandom_range(0, 3)) append_text(8'($urandom));
      end
      2: begin
        text_q = '{BomEf, BomBb, BomBf};
        repeat ($urandom_range(0, 4)) append_text(8'($urandom));
      end
      3, 4: begin
        text_q = '{BomFf, BomFe};
        add_units16(1'b1);
      end
      5, 6: begin
        text_q = '{BomFe, BomFf};
        add_units16(1'b0);
      end
      7, 8: begin
        text_q = '{BomFf, BomFe, 8'h00, 8'h00};
        add_cps32();
      end
      default: begin
        case ($urandom_range(0, 3))
          0: append_text(BomFf);
          1: append_text(BomFe);
          2: append_text(BomEf);
          default: append_text(8'($urandom));
        endcase
        repeat ($urandom_range(0, 4)) append_text(8'($urandom));
      end
    endcase
  endfunction

  // output side: random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.has_byte, out_ch.failed, out_ch.out_last};
      if (utf8_expected.size() == 0) begin
        report_mismatch("result with none pending, out_byte", got.out_byte, 8'h00);
      end else begin
        want = utf8_expected.pop_front();
        n_checked++;
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.has_byte !== want.has_byte)
          report_mismatch("has_byte", 8'(got.has_byte), 8'(want.has_byte));
        if (got.failed !== want.failed)
          report_mismatch("failed", 8'(got.failed), 8'(want.failed));
        if (got.out_last !== want.out_last)
          report_mismatch("out_last", 8'(got.out_last), 8'(want.out_last));
      end
    end
  end

  initial begin
    int rand_start;
    int waited;
    n_errors = 0;
    n_checked = 0;
    n_texts = 0;
    bytes_sent = 0;
    steady = 1'b0;
    clear_text_state();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++)
      send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      steady = ($urandom_range(0, 5) == 0);
      build_text();
      foreach (text_q[i])
        send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NoRes);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    waited = 0;
    while (utf8_expected.size() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (utf8_expected.size() > 0)
      report_mismatch("results never delivered, count", 8'(utf8_expected.size()), 8'h00);
    repeat (20) @(posedge clk_i);

    $display("tb_top: %0d bytes in %0d texts (BOM variants, surrogates, errors, partial marks)",
             bytes_sent, n_texts);
    $display("tb_top: %0d results compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bttu_pkg.sv
rtl/bttu_if.sv
rtl/bttu_front.sv
rtl/bttu_queue.sv
rtl/bttu_back.sv
rtl/bom_text_to_utf8_transcoder.sv
test/tb_top.sv
